[sv/ffba_pkg.sv]
// package for the first-fit block allocator: constants, item and control types
// no dependencies
`default_nettype none
package ffba_pkg;
  localparam int ARENA_BYTES  = 52428800;
  localparam int HEADER_BYTES = 24;
  localparam int MAX_BLOCKS   = 64;
  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [2:0] ST_ALLOCATED   = 3'd0;
  localparam logic [2:0] ST_NO_MEMORY   = 3'd1;
  localparam logic [2:0] ST_RELEASED    = 3'd2;
  localparam logic [2:0] ST_BAD_ADDRESS = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL  = 3'd4;

  localparam logic ACT_ALLOCATE = 1'b0;
  localparam logic ACT_RELEASE  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [26:0] request_size;
    logic [25:0] release_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [25:0] address;
  } out_item_t;

  typedef struct packed {
    logic [25:0] start;
    logic [25:0] len;
    logic        free;
  } entry_t;

  typedef struct packed {
    logic       load_item;
    logic       inc_idx;
    logic       rd_jm1;
    logic       sh_wr;
    logic       dec_j;
    logic       latch_hit;
    logic       wr_split;
    logic       wr_main;
    logic       set_res;
    logic [2:0] res_code;
    logic       load_out;
  } ctl_t;

  typedef struct packed {
    logic alloc;
    logic at_end;
    logic hit;
    logic need_split;
    logic full;
    logic j_done;
  } sts_t;
endpackage
`default_nettype wire

[sv/first_fit_block_allocator_top.sv]
// top level of the first-fit block allocator: controller plus datapath
// depends on ffba_pkg, ffba_ctrl, ffba_datapath
//
// usage
// - input channel in_valid_i / in_ready_o carries one item: allocate a
//   block of request_size bytes, or release the block at release_address
// - output channel out_valid_o / out_ready_i returns one item per input:
//   status and, for a successful allocate, the data address
// - one item at a time: the controller walks the block table, reading each
//   entry in states S_RD and S_CHK through the registered memory read port
// - on a hit that needs a split, the entries above the hit are first shifted
//   up one place, then the split-off free block and the allocated block are
//   written
// - reset: table holds one free block covering the arena less one header;
//   no clearing pass, entry 0 is served from its reset value until written
// - a stalled receiver holds the result in the output register; the next
//   item is still taken and worked, it waits only to hand its result over
`default_nettype none
module first_fit_block_allocator_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ffba_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output ffba_pkg::out_item_t      out_item_o
);
  ffba_pkg::ctl_t ctl;  // commands to the datapath
  ffba_pkg::sts_t sts;  // compare and count status back

  ffba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  ffba_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_item_i (in_item_i),
    .ctl_i     (ctl),
    .sts_o     (sts),
    .out_item_o(out_item_o)
  );
endmodule
`default_nettype wire

[sv/ffba_datapath.sv]
// datapath: block table memory, item, index and result registers
// depends on ffba_pkg
`default_nettype none
module ffba_datapath (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire ffba_pkg::in_item_t in_item_i,
  input  wire ffba_pkg::ctl_t   ctl_i,
  output ffba_pkg::sts_t        sts_o,
  output ffba_pkg::out_item_t   out_item_o
);
  localparam int IW = ffba_pkg::IDX_W;
  localparam int CW = ffba_pkg::CNT_W;
  localparam ffba_pkg::entry_t ENTRY0 = '{start: 26'd0,
    len: 26'(ffba_pkg::ARENA_BYTES - ffba_pkg::HEADER_BYTES), free: 1'b1};
  localparam logic [27:0] HDR = 28'(ffba_pkg::HEADER_BYTES);

  ffba_pkg::entry_t mem [ffba_pkg::MAX_BLOCKS];
  ffba_pkg::entry_t rdata_q, rd_ent, wdata;
  logic [IW-1:0] raddr, waddr;
  logic          we, rd0_q, e0w_q;
  logic          act_q, split_q;
  logic [26:0]   size_q;
  logic [25:0]   rel_q, start_q, len_q;
  logic [CW-1:0] idx_q, j_q, count_q;
  logic [2:0]    res_code_q;
  logic [25:0]   res_addr_q;
  ffba_pkg::out_item_t out_q;
  logic [27:0]   split_lim, new_start, new_len;

  assign rd_ent = (rd0_q && !e0w_q) ? ENTRY0 : rdata_q;
  assign raddr  = ctl_i.rd_jm1 ? IW'(j_q - CW'(1)) : idx_q[IW-1:0];
  assign split_lim = {1'b0, size_q} + HDR;
  assign new_start = {2'b0, start_q} + HDR + {1'b0, size_q};
  assign new_len   = {2'b0, len_q} - HDR - {1'b0, size_q};

  always_comb begin
    we = 1'b0;
    waddr = idx_q[IW-1:0];
    wdata = rd_ent;
    if (ctl_i.sh_wr) begin
      we = 1'b1;
      waddr = j_q[IW-1:0];
      wdata = rd_ent;
    end else if (ctl_i.wr_split) begin
      we = 1'b1;
      waddr = IW'(idx_q + CW'(1));
      wdata = '{start: new_start[25:0], len: new_len[25:0], free: 1'b1};
    end else if (ctl_i.wr_main) begin
      we = 1'b1;
      if (act_q == ffba_pkg::ACT_RELEASE) begin
        wdata = '{start: start_q, len: len_q, free: 1'b1};
      end else begin
        wdata = '{start: start_q, len: split_q ? size_q[25:0] : len_q, free: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  always_comb begin
    sts_o.alloc  = (act_q == ffba_pkg::ACT_ALLOCATE);
    sts_o.at_end = (idx_q >= count_q);
    if (act_q == ffba_pkg::ACT_ALLOCATE) begin
      sts_o.hit = rd_ent.free && ({1'b0, rd_ent.len} >= size_q);
    end else begin
      sts_o.hit = (({1'b0, rd_ent.start} + HDR[26:0]) == {1'b0, rel_q});
    end
    sts_o.need_split = ({2'b0, rd_ent.len} > split_lim);
    sts_o.full   = (count_q >= CW'(ffba_pkg::MAX_BLOCKS));
    sts_o.j_done = (j_q <= idx_q + CW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CW'(1);
      e0w_q   <= 1'b0;
      rd0_q   <= 1'b0;
      idx_q   <= '0;
      j_q     <= '0;
    end else begin
      rd0_q <= (raddr == '0);
      if (we && waddr == '0) e0w_q <= 1'b1;
      if (ctl_i.load_item) idx_q <= '0;
      else if (ctl_i.inc_idx) idx_q <= idx_q + CW'(1);
      if (ctl_i.latch_hit) j_q <= count_q;
      else if (ctl_i.dec_j) j_q <= j_q - CW'(1);
      if (ctl_i.wr_split) count_q <= count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_item) begin
      act_q  <= in_item_i.action;
      size_q <= in_item_i.request_size;
      rel_q  <= in_item_i.release_address;
    end
    if (ctl_i.latch_hit) begin
      start_q <= rd_ent.start;
      len_q   <= rd_ent.len;
      split_q <= (act_q == ffba_pkg::ACT_ALLOCATE) && sts_o.need_split;
    end
    if (ctl_i.set_res) begin
      res_code_q <= ctl_i.res_code;
      res_addr_q <= (ctl_i.res_code == ffba_pkg::ST_ALLOCATED)
                    ? 26'({1'b0, start_q} + HDR[26:0]) : 26'd0;
    end
    if (ctl_i.load_out) begin
      out_q.status  <= res_code_q;
      out_q.address <= res_addr_q;
    end
  end

  assign out_item_o = out_q;
endmodule
`default_nettype wire

[sv/ffba_ctrl.sv]
// controller state machine: table scan, shift, write and result sequencing
// depends on ffba_pkg
`default_nettype none
module ffba_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire ffba_pkg::sts_t sts_i,
  output ffba_pkg::ctl_t      ctl_o
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_SHRD  = 3'd3;
  localparam logic [2:0] S_SHWR  = 3'd4;
  localparam logic [2:0] S_SPLIT = 3'd5;
  localparam logic [2:0] S_MAIN  = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  logic [2:0] state_q, state_d;
  logic       ov_q, ov_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    ov_d = ov_q && !out_ready_i;
    ctl_o = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.load_item = 1'b1;
          state_d = S_RD;
        end
      end
      S_RD: begin
        if (sts_i.at_end) begin
          ctl_o.set_res = 1'b1;
          ctl_o.res_code = sts_i.alloc ? ffba_pkg::ST_NO_MEMORY : ffba_pkg::ST_BAD_ADDRESS;
          state_d = S_DONE;
        end else begin
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (sts_i.hit) begin
          ctl_o.latch_hit = 1'b1;
          if (sts_i.alloc && sts_i.need_split) begin
            if (sts_i.full) begin
              ctl_o.set_res = 1'b1;
              ctl_o.res_code = ffba_pkg::ST_TABLE_FULL;
              state_d = S_DONE;
            end else begin
              state_d = S_SHRD;
            end
          end else begin
            state_d = S_MAIN;
          end
        end else begin
          ctl_o.inc_idx = 1'b1;
          state_d = S_RD;
        end
      end
      S_SHRD: begin
        if (sts_i.j_done) begin
          state_d = S_SPLIT;
        end else begin
          ctl_o.rd_jm1 = 1'b1;
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        ctl_o.sh_wr = 1'b1;
        ctl_o.dec_j = 1'b1;
        state_d = S_SHRD;
      end
      S_SPLIT: begin
        ctl_o.wr_split = 1'b1;
        state_d = S_MAIN;
      end
      S_MAIN: begin
        ctl_o.wr_main = 1'b1;
        ctl_o.set_res = 1'b1;
        ctl_o.res_code = sts_i.alloc ? ffba_pkg::ST_ALLOCATED : ffba_pkg::ST_RELEASED;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_q || out_ready_i) begin
          ctl_o.load_out = 1'b1;
          ov_d = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end
endmodule
`default_nettype wire

[sv/ffba_checker.sv]
// port-level checker for the first-fit block allocator, bound to the top
// depends on ffba_pkg
`default_nettype none
module ffba_checker (
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_o,
  input wire logic                out_valid_o,
  input wire logic                out_ready_i,
  input wire ffba_pkg::out_item_t out_item_o
);
  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result changed while stalled");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after accept");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status <= ffba_pkg::ST_TABLE_FULL)
    else $error("status code out of range");

  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ffba_pkg::ST_ALLOCATED |->
      out_item_o.address == 26'd0)
    else $error("address set without allocation");
endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_item_o (out_item_o)
);
`default_nettype wire
